// ----- rtl/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// Ray box slab test package
// Shared types and constants for the 2D ray versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

   // Face normal component: -1, 0 or +1 in two's complement.
   typedef logic signed [1:0] normal_type;

   localparam normal_type NORMAL_NEG  = 2'sb11;
   localparam normal_type NORMAL_ZERO = 2'sb00;
   localparam normal_type NORMAL_POS  = 2'sb01;

endpackage

// ----- rtl/rbst_req_if.sv -----
// ----------------------------------------------------------------------------
// Ray box slab test request channel
// Valid/ready channel that carries one box and one ray segment per transaction.
// ----------------------------------------------------------------------------
interface rbst_req_if #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic        [FRAC_BITS:0]     max_fraction;

   modport source (
      output valid, box_min_x, box_min_y, box_max_x, box_max_y,
      output start_x, start_y, end_x, end_y, max_fraction,
      input  ready
   );

   modport sink (
      input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
      input  start_x, start_y, end_x, end_y, max_fraction,
      output ready
   );
endinterface

// ----- rtl/rbst_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Ray box slab test response channel
// Valid/ready channel that carries one hit result per transaction.
// ----------------------------------------------------------------------------
interface rbst_rsp_if #(
   parameter int FRAC_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [FRAC_BITS:0]   hit_fraction;
   rbst_pkg::normal_type normal_x;
   rbst_pkg::normal_type normal_y;

   modport source (
      output valid, hit, hit_fraction, normal_x, normal_y,
      input  ready
   );

   modport sink (
      input  valid, hit, hit_fraction, normal_x, normal_y,
      output ready
   );
endinterface

// ----- rtl/ray_box_slab_test_2d.sv -----
// ----------------------------------------------------------------------------
// Ray box slab test, 2D
// Slab-method intersection of a ray segment with an axis-aligned box in
// signed fixed point, reporting hit, entry fraction and entry face normal.
// ----------------------------------------------------------------------------
// The block takes one query per clock cycle while nothing stalls and returns
// one response per query, in order. The pipeline wraps four parallel
// restoring dividers, which take FRAC_BITS + 4 stages: an overflow check,
// then one quotient bit per stage. Every stage holds its own valid bit, so a
// stall on the response side only holds the stages that are full and
// bubbles close up before the request side sees back-pressure. Slab
// parameters are clamped to just under 8.0, which keeps the hit decision,
// fraction and normal identical to the unclamped result.
// ----------------------------------------------------------------------------
module ray_box_slab_test_2d #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   rbst_req_if.sink    req_ch,
   rbst_rsp_if.source  rsp_ch
);

   localparam int DW  = COORD_WIDTH + 1;   // difference width
   localparam int QB  = FRAC_BITS + 3;     // quotient bits, three integer bits
   localparam int TW  = QB + 2;            // running t width, signed
   localparam int NST = QB + 7;            // pipeline stages
   localparam int SA  = 0;
   localparam int SB  = 1;
   localparam int SD  = 2;
   localparam int SP1 = QB + 3;
   localparam int SP2 = QB + 4;
   localparam int SP3 = QB + 5;
   localparam int SP4 = QB + 6;

   localparam logic signed [TW-1:0] T_FLOOR = {2'b11, {QB{1'b0}}};
   localparam logic signed [TW-1:0] T_CEIL  = {2'b01, {QB{1'b0}}};

   // Side information that travels with each transaction.
   typedef struct packed {
      logic               dz_x;
      logic               in_x;
      logic               dz_y;
      logic               in_y;
      logic [3:0]         neg;
      logic [FRAC_BITS:0] maxf;
   } side_type;

   // Valid bits and per-stage enables.
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] en;

   always_comb begin
      en[NST-1] = !vld_ff[NST-1] | rsp_ch.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] | en[i+1];
      end
      vld_in[0] = en[0] ? req_ch.valid : vld_ff[0];
      for (int i = 1; i < NST; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = en[0];

   // Stage A: directions, bound offsets and zero-direction checks.
   logic signed [DW-1:0] sx_e, sy_e, ex_e, ey_e, lx_e, ly_e, hx_e, hy_e;
   logic signed [DW-1:0] dir_x_ff, dir_y_ff;
   logic signed [DW-1:0] num_a_ff [4];
   side_type             side_ff [0:SP2];
   side_type             side_a_in;

   always_comb begin
      sx_e = {req_ch.start_x[COORD_WIDTH-1], req_ch.start_x};
      sy_e = {req_ch.start_y[COORD_WIDTH-1], req_ch.start_y};
      ex_e = {req_ch.end_x[COORD_WIDTH-1], req_ch.end_x};
      ey_e = {req_ch.end_y[COORD_WIDTH-1], req_ch.end_y};
      lx_e = {req_ch.box_min_x[COORD_WIDTH-1], req_ch.box_min_x};
      ly_e = {req_ch.box_min_y[COORD_WIDTH-1], req_ch.box_min_y};
      hx_e = {req_ch.box_max_x[COORD_WIDTH-1], req_ch.box_max_x};
      hy_e = {req_ch.box_max_y[COORD_WIDTH-1], req_ch.box_max_y};
      side_a_in.dz_x = (req_ch.end_x == req_ch.start_x);
      side_a_in.dz_y = (req_ch.end_y == req_ch.start_y);
      side_a_in.in_x = !(sx_e < lx_e || sx_e > hx_e);
      side_a_in.in_y = !(sy_e < ly_e || sy_e > hy_e);
      side_a_in.neg  = '0;
      side_a_in.maxf = req_ch.max_fraction;
   end

   always_ff @(posedge clock) begin
      if (en[SA]) begin
         dir_x_ff    <= ex_e - sx_e;
         dir_y_ff    <= ey_e - sy_e;
         num_a_ff[0] <= lx_e - sx_e;
         num_a_ff[1] <= hx_e - sx_e;
         num_a_ff[2] <= ly_e - sy_e;
         num_a_ff[3] <= hy_e - sy_e;
         side_ff[SA] <= side_a_in;
      end
   end

   // Stage B: magnitudes and quotient signs.
   logic [DW-1:0] nmag_ff [4];
   logic [DW-1:0] dmag_x_ff, dmag_y_ff;
   side_type      side_b_in;

   always_comb begin
      side_b_in        = side_ff[SA];
      side_b_in.neg[0] = num_a_ff[0][DW-1] ^ dir_x_ff[DW-1];
      side_b_in.neg[1] = num_a_ff[1][DW-1] ^ dir_x_ff[DW-1];
      side_b_in.neg[2] = num_a_ff[2][DW-1] ^ dir_y_ff[DW-1];
      side_b_in.neg[3] = num_a_ff[3][DW-1] ^ dir_y_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (en[SB]) begin
         for (int l = 0; l < 4; l++) begin
            nmag_ff[l] <= num_a_ff[l][DW-1] ? DW'(-num_a_ff[l]) : DW'(num_a_ff[l]);
         end
         dmag_x_ff   <= dir_x_ff[DW-1] ? DW'(-dir_x_ff) : DW'(dir_x_ff);
         dmag_y_ff   <= dir_y_ff[DW-1] ? DW'(-dir_y_ff) : DW'(dir_y_ff);
         side_ff[SB] <= side_b_in;
      end
   end

   // Side information follows the dividers.
   for (genvar g = SD; g <= SP2; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[g]) begin
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   // Four dividers: x low, x high, y low, y high.
   logic [QB-1:0] quot [4];
   logic [3:0]    sat;

   for (genvar l = 0; l < 4; l++) begin : g_lane
      rbst_div #(
         .NUM_WIDTH (DW),
         .QUOT_BITS (QB)
      ) u_div (
         .clock (clock),
         .en    (en[SD +: QB+1]),
         .num   (nmag_ff[l]),
         .den   ((l < 2) ? dmag_x_ff : dmag_y_ff),
         .quot  (quot[l]),
         .sat   (sat[l])
      );
   end

   // Stage P1: clamp and apply signs.
   logic signed [QB:0] t_p1_ff [4];

   always_ff @(posedge clock) begin
      if (en[SP1]) begin
         for (int l = 0; l < 4; l++) begin
            if (side_ff[SP1-1].neg[l]) begin
               t_p1_ff[l] <= -$signed({1'b0, (sat[l] ? {QB{1'b1}} : quot[l])});
            end else begin
               t_p1_ff[l] <= $signed({1'b0, (sat[l] ? {QB{1'b1}} : quot[l])});
            end
         end
      end
   end

   // Stage P2: order each slab's entry and exit.
   logic signed [QB:0] tn_x_ff, tf_x_ff, tn_y_ff, tf_y_ff;
   logic               sw_x_ff, sw_y_ff;
   logic               sw_x, sw_y;

   always_comb begin
      sw_x = (t_p1_ff[0] > t_p1_ff[1]);
      sw_y = (t_p1_ff[2] > t_p1_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en[SP2]) begin
         tn_x_ff <= sw_x ? t_p1_ff[1] : t_p1_ff[0];
         tf_x_ff <= sw_x ? t_p1_ff[0] : t_p1_ff[1];
         tn_y_ff <= sw_y ? t_p1_ff[3] : t_p1_ff[2];
         tf_y_ff <= sw_y ? t_p1_ff[2] : t_p1_ff[3];
         sw_x_ff <= sw_x;
         sw_y_ff <= sw_y;
      end
   end

   // Stage P3: combine both slabs into the running entry and exit.
   logic signed [TW-1:0] tmin_x, tmax_x, tmin_in, tmax_in;
   logic signed [TW-1:0] tn_y_e, tf_y_e;
   rbst_pkg::normal_type fx, nx_in, ny_in;
   logic                 ok_x, ok_in;
   logic signed [TW-1:0] tmin_ff;
   rbst_pkg::normal_type nx_ff, ny_ff;
   logic                 ok_ff;
   logic [FRAC_BITS:0]   maxf_ff;

   always_comb begin
      tn_y_e = TW'(tn_y_ff);
      tf_y_e = TW'(tf_y_ff);
      if (side_ff[SP2].dz_x) begin
         ok_x   = side_ff[SP2].in_x;
         tmin_x = T_FLOOR;
         tmax_x = T_CEIL;
         fx     = rbst_pkg::NORMAL_ZERO;
      end else begin
         ok_x   = 1'b1;
         tmin_x = TW'(tn_x_ff);
         tmax_x = TW'(tf_x_ff);
         fx     = sw_x_ff ? rbst_pkg::NORMAL_POS : rbst_pkg::NORMAL_NEG;
      end
      tmin_in = tmin_x;
      tmax_in = tmax_x;
      nx_in   = fx;
      ny_in   = rbst_pkg::NORMAL_ZERO;
      if (!ok_x) begin
         ok_in = 1'b0;
      end else if (side_ff[SP2].dz_y) begin
         ok_in = side_ff[SP2].in_y;
      end else begin
         if (tn_y_e > tmin_x) begin
            tmin_in = tn_y_e;
            nx_in   = rbst_pkg::NORMAL_ZERO;
            ny_in   = sw_y_ff ? rbst_pkg::NORMAL_POS : rbst_pkg::NORMAL_NEG;
         end
         if (tf_y_e < tmax_x) begin
            tmax_in = tf_y_e;
         end
         ok_in = !(tmin_in > tmax_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en[SP3]) begin
         ok_ff   <= ok_in;
         tmin_ff <= tmin_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         maxf_ff <= side_ff[SP2].maxf;
      end
   end

   // Stage P4: range check against zero and the largest fraction.
   logic                 hit_in;
   logic                 hit_ff;
   logic [FRAC_BITS:0]   frac_ff;
   rbst_pkg::normal_type onx_ff, ony_ff;

   always_comb begin
      hit_in = ok_ff && !tmin_ff[TW-1] && ($unsigned(tmin_ff) <= TW'(maxf_ff));
   end

   always_ff @(posedge clock) begin
      if (en[SP4]) begin
         hit_ff  <= hit_in;
         frac_ff <= hit_in ? tmin_ff[FRAC_BITS:0] : '0;
         onx_ff  <= hit_in ? nx_ff : rbst_pkg::NORMAL_ZERO;
         ony_ff  <= hit_in ? ny_ff : rbst_pkg::NORMAL_ZERO;
      end
   end

   assign rsp_ch.valid        = vld_ff[SP4];
   assign rsp_ch.hit          = hit_ff;
   assign rsp_ch.hit_fraction = frac_ff;
   assign rsp_ch.normal_x     = onx_ff;
   assign rsp_ch.normal_y     = ony_ff;

`ifndef ASSERT_OFF
   // A hit always names exactly one entry face.
   a_hit_one_face: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.hit |->
      $countones({rsp_ch.normal_x != rbst_pkg::NORMAL_ZERO,
                  rsp_ch.normal_y != rbst_pkg::NORMAL_ZERO}) == 1)
      else $error("hit without exactly one face normal");

   // A miss carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.hit |->
      rsp_ch.hit_fraction == '0 && rsp_ch.normal_x == rbst_pkg::NORMAL_ZERO &&
      rsp_ch.normal_y == rbst_pkg::NORMAL_ZERO)
      else $error("miss with nonzero fields");

   // A full stage that cannot drain keeps its transaction.
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SP2] && !en[SP3] |=> vld_ff[SP2])
      else $error("stalled stage dropped its transaction");

   // An accepted transaction lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[SA])
      else $error("accepted transaction lost at entry");
`endif

endmodule

// ----- rtl/rbst_div.sv -----
// ----------------------------------------------------------------------------
// Ray box slab test divider
// Pipelined restoring divider: an overflow check, then one quotient bit per
// stage, and an overflow flag when the quotient does not fit in QUOT_BITS bits.
// ----------------------------------------------------------------------------
module rbst_div #(
   parameter int NUM_WIDTH = 33,
   parameter int QUOT_BITS = 19
) (
   input  logic                 clock,
   input  logic [QUOT_BITS:0]   en,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [NUM_WIDTH-1:0] den,
   output logic [QUOT_BITS-1:0] quot,
   output logic                 sat
);

   // The divisor is scaled by eight so the quotient carries three integer bits.
   localparam int RW = NUM_WIDTH + 3;

   logic [RW-1:0]        rem_ff [0:QUOT_BITS];
   logic [RW-1:0]        dsc_ff [0:QUOT_BITS];
   logic [QUOT_BITS-1:0] quo_ff [0:QUOT_BITS];
   logic [QUOT_BITS:0]   sat_ff;

   logic [RW-1:0] num_ext;
   logic [RW-1:0] dsc_in;
   logic          sat_in;

   // First stage: overflow check against the scaled divisor.
   always_comb begin
      num_ext = RW'(num);
      dsc_in  = {den, 3'b000};
      sat_in  = (num_ext >= dsc_in);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= sat_in ? '0 : num_ext;
         dsc_ff[0] <= dsc_in;
         quo_ff[0] <= '0;
         sat_ff[0] <= sat_in;
      end
   end

   // One shift, compare and subtract per stage.
   for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_step
      logic [RW:0] twice;
      logic [RW:0] diff;
      logic        ge;

      always_comb begin
         twice = {rem_ff[k-1], 1'b0};
         diff  = twice - {1'b0, dsc_ff[k-1]};
         ge    = (twice >= {1'b0, dsc_ff[k-1]});
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= ge ? diff[RW-1:0] : twice[RW-1:0];
            dsc_ff[k] <= dsc_ff[k-1];
            quo_ff[k] <= {quo_ff[k-1][QUOT_BITS-2:0], ge};
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign quot = quo_ff[QUOT_BITS];
   assign sat  = sat_ff[QUOT_BITS];

endmodule
